>>> src/agps_pkg.sv
// Package of shared types and constants for the affine gap path scorer.
package agps_pkg;

  // Item function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PATH = 1'b1;

  // Column kinds. Code 3 is unused but is still recorded as the previous kind.
  localparam logic [1:0] KIND_MATCH = 2'd0;
  localparam logic [1:0] KIND_DEL   = 2'd1;
  localparam logic [1:0] KIND_INS   = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_GAP_OPEN   = 1'b0;
  localparam logic REG_GAP_EXTEND = 1'b1;

  localparam int unsigned PenWidth   = 10;
  localparam int unsigned ScoreWidth = 32;
  localparam int unsigned WideWidth  = 34;
  localparam int unsigned CodeWidth  = 8;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [PenWidth-1:0] GAP_OPEN_RST   = 10'd29;
  localparam logic [PenWidth-1:0] GAP_EXTEND_RST = 10'd3;

  localparam logic signed [WideWidth-1:0] SCORE_MAX_W = 34'sd2147483647;
  localparam logic signed [WideWidth-1:0] SCORE_MIN_W = -34'sd2147483648;

  typedef struct packed {
    logic [PenWidth-1:0] open_pen;
    logic [PenWidth-1:0] extend_pen;
  } gap_cfg_t;

  // Control fields of an item held in the score stage.
  typedef struct packed {
    logic       func;
    logic [1:0] op;
    logic       first;
    logic       last;
    logic       in_alpha;
  } item_ctl_t;

endpackage

>>> src/agps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module agps_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/agps_cfg.sv
// Configuration registers behind the APB-style port: gap open and gap extend penalties.
module agps_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [agps_pkg::ApbAddrW-1:0]     paddr,
  input  logic [agps_pkg::ApbDataW-1:0]     pwdata,
  output logic [agps_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output agps_pkg::gap_cfg_t                gap_o
);

  agps_pkg::gap_cfg_t gap_q, gap_d;
  logic               reg_idx;
  logic               wr_en;

  // Registers sit on word boundaries, so bit 2 picks the register.
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    gap_d = gap_q;
    if (wr_en) begin
      case (reg_idx)
        agps_pkg::REG_GAP_OPEN:   gap_d.open_pen   = pwdata[agps_pkg::PenWidth-1:0];
        agps_pkg::REG_GAP_EXTEND: gap_d.extend_pen = pwdata[agps_pkg::PenWidth-1:0];
        default:                  gap_d = gap_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      agps_pkg::REG_GAP_OPEN:   prdata = agps_pkg::ApbDataW'(gap_q.open_pen);
      agps_pkg::REG_GAP_EXTEND: prdata = agps_pkg::ApbDataW'(gap_q.extend_pen);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q.open_pen   <= agps_pkg::GAP_OPEN_RST;
      gap_q.extend_pen <= agps_pkg::GAP_EXTEND_RST;
    end else begin
      gap_q <= gap_d;
    end
  end

  assign gap_o = gap_q;

endmodule

>>> src/agps_acc.sv
// Score stage: running score, previous column kind, saturation flag and the result register.
module agps_acc #(
  parameter int unsigned EntryWidth = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  agps_pkg::item_ctl_t                  item_i,
  input  logic                                 go_i,
  input  logic signed [EntryWidth-1:0]         entry_i,
  input  agps_pkg::gap_cfg_t                   gap_i,
  input  logic                                 out_stall_i,
  output logic                                 out_free_o,
  output logic                                 out_valid_o,
  output logic signed [agps_pkg::ScoreWidth-1:0] score_o,
  output logic                                 overflow_o
);

  logic signed [agps_pkg::ScoreWidth-1:0] score_q, score_d, base_score;
  logic [1:0]                             kind_q, kind_d, base_kind;
  logic                                   sat_q, sat_d, base_sat;
  logic signed [agps_pkg::WideWidth-1:0]  delta, sum_w;
  logic [agps_pkg::PenWidth-1:0]          pen;
  logic                                   is_path, emit;
  logic                                   out_valid_q, out_valid_d;
  logic signed [agps_pkg::ScoreWidth-1:0] out_score_q;
  logic                                   out_ovf_q;

  assign is_path = go_i & (item_i.func == agps_pkg::FUNC_PATH);
  assign emit    = is_path & item_i.last;

  // A first column restarts the path before it is scored.
  assign base_score = item_i.first ? '0 : score_q;
  assign base_kind  = item_i.first ? agps_pkg::KIND_MATCH : kind_q;
  assign base_sat   = item_i.first ? 1'b0 : sat_q;

  assign pen = (base_kind == item_i.op) ? gap_i.extend_pen : gap_i.open_pen;

  always_comb begin
    case (item_i.op)
      agps_pkg::KIND_MATCH: delta = item_i.in_alpha ? agps_pkg::WideWidth'(entry_i) : '0;
      agps_pkg::KIND_DEL,
      agps_pkg::KIND_INS:   delta = -$signed(agps_pkg::WideWidth'(pen));
      default:              delta = '0;
    endcase
  end

  assign sum_w = agps_pkg::WideWidth'(base_score) + delta;

  always_comb begin
    score_d = score_q;
    kind_d  = kind_q;
    sat_d   = sat_q;
    if (is_path) begin
      kind_d = item_i.op;
      sat_d  = base_sat;
      if (sum_w > agps_pkg::SCORE_MAX_W) begin
        score_d = agps_pkg::ScoreWidth'(agps_pkg::SCORE_MAX_W);
        sat_d   = 1'b1;
      end else if (sum_w < agps_pkg::SCORE_MIN_W) begin
        score_d = agps_pkg::ScoreWidth'(agps_pkg::SCORE_MIN_W);
        sat_d   = 1'b1;
      end else begin
        score_d = sum_w[agps_pkg::ScoreWidth-1:0];
      end
    end
  end

  assign out_free_o  = ~out_valid_q | ~out_stall_i;
  assign out_valid_d = emit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q     <= '0;
      kind_q      <= agps_pkg::KIND_MATCH;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      score_q     <= score_d;
      kind_q      <= kind_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_score_q <= score_d;
      out_ovf_q   <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = out_score_q;
  assign overflow_o  = out_ovf_q;

endmodule

>>> src/affine_gap_path_scorer.sv
// Top level of the affine gap path scorer: input stage, substitution table and score stage.
//
// Use: items arrive on the input channel (in_valid_i / in_stall_o) one beat at a time.
// A load beat (func 0) writes one signed substitution entry at row code_a, column code_b
// of the on-chip table. A path beat (func 1) scores one alignment column: a match adds
// the table entry, a deletion or insertion subtracts gap_extend when it continues a gap
// of the same kind and gap_open otherwise. first clears the path state, last makes the
// block emit one result beat (score_o, overflow_o) on the output channel.
// The table is read and the beat's control fields are registered at the edge that
// accepts a beat; the column is scored from those registers, and its result is
// registered in the output register that drives score_o and overflow_o.
// Throughput: one beat per cycle while in_stall_o is low, set by the single read port
// of the table and the one 34-bit add and clamp in the score stage; a load may be
// followed at once by a match on the same entry, as the write lands before the next read.
// When the receiver stalls, the result stays in the output register. Columns that do not
// close a path keep flowing through the score stage; a path beat with last waits
// there, and in_stall_o stays high until the result ahead of it drains.
// Reset clears the running score, saturation flag and previous kind and restores the
// gap penalties to 29 and 3; the table contents are undefined until loaded.
module affine_gap_path_scorer #(
  parameter int unsigned AlphabetSize = 256,
  parameter int unsigned EntryWidth   = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Input channel.
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    func_i,
  input  logic [1:0]                              op_i,
  input  logic [agps_pkg::CodeWidth-1:0]          code_a_i,
  input  logic [agps_pkg::CodeWidth-1:0]          code_b_i,
  input  logic signed [15:0]                      entry_value_i,
  input  logic                                    first_i,
  input  logic                                    last_i,
  // Output channel.
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [agps_pkg::ScoreWidth-1:0]  score_o,
  output logic                                    overflow_o,
  // Configuration port.
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [agps_pkg::ApbAddrW-1:0]           paddr,
  input  logic [agps_pkg::ApbDataW-1:0]           pwdata,
  output logic [agps_pkg::ApbDataW-1:0]           prdata,
  output logic                                    pready
);

  localparam int unsigned TableDepth = AlphabetSize * AlphabetSize;
  localparam int unsigned TableAw    = $clog2(TableDepth);

  agps_pkg::gap_cfg_t           gap;
  agps_pkg::item_ctl_t          s1_q, s1_d;
  logic                         s1_valid_q;
  logic                         in_alpha, accept, go, s1_ready, out_free;
  logic [TableAw-1:0]           tbl_addr;
  logic [EntryWidth-1:0]        tbl_rdata;
  logic [EntryWidth-1:0]        tbl_wdata;

  agps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .gap_o   (gap)
  );

  // Codes at or beyond the alphabet size never touch the table.
  assign in_alpha = ({1'b0, code_a_i} < 9'(AlphabetSize))
                  & ({1'b0, code_b_i} < 9'(AlphabetSize));

  assign tbl_addr  = TableAw'(code_a_i) * TableAw'(AlphabetSize) + TableAw'(code_b_i);
  assign tbl_wdata = EntryWidth'(entry_value_i);

  // The score stage advances unless it would emit into a full, stalled result register.
  assign go = s1_valid_q
            & (~((s1_q.func == agps_pkg::FUNC_PATH) & s1_q.last) | out_free);
  assign s1_ready   = ~s1_valid_q | go;
  assign in_stall_o = ~s1_ready;
  assign accept     = in_valid_i & s1_ready;

  agps_ram #(
    .Width (EntryWidth),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept & (func_i == agps_pkg::FUNC_LOAD) & in_alpha),
    .waddr_i (tbl_addr),
    .wdata_i (tbl_wdata),
    .re_i    (accept),
    .raddr_i (tbl_addr),
    .rdata_o (tbl_rdata)
  );

  always_comb begin
    s1_d.func     = func_i;
    s1_d.op       = op_i;
    s1_d.first    = first_i;
    s1_d.last     = last_i;
    s1_d.in_alpha = in_alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  agps_acc #(
    .EntryWidth (EntryWidth)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (s1_q),
    .go_i        (go),
    .entry_i     ($signed(tbl_rdata)),
    .gap_i       (gap),
    .out_stall_i (out_stall_i),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .score_o     (score_o),
    .overflow_o  (overflow_o)
  );

endmodule

>>> sim/affine_gap_path_scorer_tb.sv
// Self-checking testbench for the affine gap path scorer.
`timescale 1ns / 1ps

module affine_gap_path_scorer_tb;

  // The package names three column kinds; the fourth code is legal on the wire and
  // behaves as a spare kind that scores nothing but still breaks a gap run.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  // One input beat, field for field as the ports carry it.
  typedef struct {
    logic              func;
    logic [1:0]        op;
    logic [7:0]        code_a;
    logic [7:0]        code_b;
    logic signed [15:0] entry;
    logic              first;
    logic              last;
  } beat_t;

  // One result beat.
  typedef struct {
    logic signed [31:0] score;
    logic               overflow;
  } score_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               func_i = agps_pkg::FUNC_LOAD;
  logic [1:0]         op_i = agps_pkg::KIND_MATCH;
  logic [7:0]         code_a_i = '0;
  logic [7:0]         code_b_i = '0;
  logic signed [15:0] entry_value_i = '0;
  logic               first_i = 1'b0;
  logic               last_i = 1'b0;

  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] score_o;
  logic               overflow_o;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  affine_gap_path_scorer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .op_i          (op_i),
    .code_a_i      (code_a_i),
    .code_b_i      (code_b_i),
    .entry_value_i (entry_value_i),
    .first_i       (first_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .score_o       (score_o),
    .overflow_o    (overflow_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stimulus side: beats waiting to be sent, and which table entries the stimulus has
  // already loaded, so that a column never reads an entry that holds nothing defined.
  beat_t pending_beats[$];
  int    loaded_keys[$];
  bit    key_loaded [0:65535];
  int    beats_queued = 0;

  // Idle control. A rate of N starts a burst with a chance of one in N; zero means
  // that side never idles.
  int send_idle_rate = 0;
  int recv_idle_rate = 0;
  int send_gap = 0;
  int recv_gap = 0;

  // Predicted state of the scorer: its own copy of the table, the path accumulator and
  // the two gap penalties as last written over the configuration port.
  logic signed [15:0] subst_copy [0:65535];
  logic signed [31:0] path_sum = '0;
  logic [1:0]         path_prev = agps_pkg::KIND_MATCH;
  logic               path_sat = 1'b0;
  int                 open_pen = int'(agps_pkg::GAP_OPEN_RST);
  int                 extend_pen = int'(agps_pkg::GAP_EXTEND_RST);

  score_t expected_scores[$];
  int     mismatch_count = 0;

  // Applies one accepted beat to the predicted state. Returns 1 when the beat closes a
  // path, with the score and overflow flag that the block has to emit for it.
  function automatic bit score_beat(input beat_t b, output score_t res);
    longint sum;
    res.score = '0;
    res.overflow = 1'b0;
    if (b.func == agps_pkg::FUNC_LOAD) begin
      subst_copy[{b.code_a, b.code_b}] = b.entry;
      return 1'b0;
    end
    if (b.first) begin
      path_sum = '0;
      path_prev = agps_pkg::KIND_MATCH;
      path_sat = 1'b0;
    end
    sum = path_sum;
    if (b.op == agps_pkg::KIND_MATCH) begin
      sum += subst_copy[{b.code_a, b.code_b}];
    end else if (b.op == agps_pkg::KIND_DEL || b.op == agps_pkg::KIND_INS) begin
      // A gap continues only when the column before was the very same kind of gap.
      sum -= (path_prev == b.op) ? extend_pen : open_pen;
    end
    // Each column is clamped on its own, and the path carries on from the clamped value.
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
      path_sat = 1'b1;
    end else if (sum < SUM_MIN) begin
      sum = SUM_MIN;
      path_sat = 1'b1;
    end
    path_sum = 32'(sum);
    path_prev = b.op;
    res.score = path_sum;
    res.overflow = path_sat;
    return b.last;
  endfunction

  task automatic queue_load(input int key, input logic signed [15:0] value,
                            input bit first_flag, input bit last_flag);
    beat_t b;
    b.func = agps_pkg::FUNC_LOAD;
    b.op = 2'($urandom);
    b.code_a = key[15:8];
    b.code_b = key[7:0];
    b.entry = value;
    b.first = first_flag;
    b.last = last_flag;
    pending_beats.push_back(b);
    beats_queued++;
    if (!key_loaded[key]) begin
      key_loaded[key] = 1'b1;
      loaded_keys.push_back(key);
    end
  endtask

  task automatic queue_column(input logic [1:0] kind, input int key,
                              input bit first_flag, input bit last_flag);
    beat_t b;
    b.func = agps_pkg::FUNC_PATH;
    b.op = kind;
    b.code_a = key[15:8];
    b.code_b = key[7:0];
    // The entry field means nothing on a column, so it carries noise.
    b.entry = 16'($urandom);
    b.first = first_flag;
    b.last = last_flag;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // A load with random content: mostly a fresh entry, sometimes an overwrite, and the
  // first and last flags set at random since a load must ignore them.
  task automatic queue_random_load();
    int key;
    logic signed [15:0] value;
    key = ($urandom_range(3) == 0) ? loaded_keys[$urandom_range(loaded_keys.size() - 1)]
                                   : int'($urandom_range(65535));
    case ($urandom_range(7))
      0: value = 16'sh7fff;
      1: value = 16'sh8000;
      2: value = 16'($urandom_range(8)) - 16'sd4;
      default: value = 16'($urandom);
    endcase
    queue_load(key, value, 1'($urandom), 1'($urandom));
  endtask

  // Random traffic: mostly well-formed paths (first on the opening column, last on the
  // closing one) with runs of gaps so that both penalties are hit, and now and then a
  // path that lacks its first or last flag, or a load slipped in between columns.
  task automatic queue_random_items(input int count);
    int start;
    int len;
    int run;
    int col;
    int shape;
    int pick;
    bit with_first;
    bit with_last;
    logic [1:0] kind;
    start = beats_queued;
    while (beats_queued - start < count) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(3, 1)) queue_random_load();
      end
      shape = $urandom_range(19);
      with_first = (shape != 0);
      with_last = (shape != 1);
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      col = 0;
      while (col < len) begin
        pick = $urandom_range(10);
        if (pick <= 3) begin
          kind = agps_pkg::KIND_MATCH;
        end else if (pick <= 6) begin
          kind = agps_pkg::KIND_DEL;
        end else if (pick <= 9) begin
          kind = agps_pkg::KIND_INS;
        end else begin
          kind = KIND_SPARE;
        end
        run = (kind == agps_pkg::KIND_DEL || kind == agps_pkg::KIND_INS)
            ? $urandom_range(4, 1) : 1;
        repeat (run) begin
          if (col < len) begin
            if ($urandom_range(29) == 0) queue_random_load();
            queue_column(kind, loaded_keys[$urandom_range(loaded_keys.size() - 1)],
                         col == 0 && with_first, col == len - 1 && with_last);
            col++;
          end
        end
      end
    end
  endtask

  // One register write: setup cycle, then access cycle until pready is seen high.
  task automatic write_reg(input logic idx, input logic [9:0] value);
    logic [31:0] junk;
    junk = $urandom;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk[31:10], value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == agps_pkg::REG_GAP_OPEN) begin
      open_pen = int'(value);
    end else begin
      extend_pen = int'(value);
    end
    @(negedge clk_i);
  endtask

  // Waits until every queued beat is in and every predicted result is out, then lets
  // the pipeline settle, since a column without last leaves no trace behind.
  task automatic wait_drained(input int settle);
    while (pending_beats.size() != 0 || in_valid_i || expected_scores.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (settle) @(negedge clk_i);
  endtask

  // Input driver. A new beat is put on the wires only when the current one has been
  // taken, or when nothing is on the wires; an idle burst is armed after a beat and
  // runs out before the next one is offered.
  always @(posedge clk_i) begin : drive_beats
    beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        in_valid_i <= 1'b1;
        func_i <= nxt.func;
        op_i <= nxt.op;
        code_a_i <= nxt.code_a;
        code_b_i <= nxt.code_b;
        entry_value_i <= nxt.entry;
        first_i <= nxt.first;
        last_i <= nxt.last;
        if (send_idle_rate != 0 && $urandom_range(send_idle_rate - 1) == 0) begin
          send_gap = $urandom_range(13, 1);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver. It stalls in bursts whenever its rate allows.
  always @(posedge clk_i) begin : drive_stall
    if (recv_gap != 0) begin
      out_stall_i <= 1'b1;
      recv_gap = recv_gap - 1;
    end else if (recv_idle_rate != 0 && $urandom_range(recv_idle_rate - 1) == 0) begin
      out_stall_i <= 1'b1;
      recv_gap = $urandom_range(12, 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor for both channels. A result beat is checked against the oldest prediction
  // before the beat accepted at the same edge adds its own, so the order is fixed by
  // this block alone and not by the scheduler.
  always @(posedge clk_i) begin : check_scores
    beat_t  taken;
    score_t want;
    score_t fresh;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with none expected, score %0d overflow %0b",
                   $time, score_o, overflow_o);
        end else begin
          want = expected_scores.pop_front();
          if (score_o !== want.score) begin
            mismatch_count++;
            $display("%0t: score mismatch, expected %0d, got %0d",
                     $time, want.score, score_o);
          end
          if (overflow_o !== want.overflow) begin
            mismatch_count++;
            $display("%0t: overflow mismatch, expected %0b, got %0b",
                     $time, want.overflow, overflow_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        taken.func = func_i;
        taken.op = op_i;
        taken.code_a = code_a_i;
        taken.code_b = code_b_i;
        taken.entry = entry_value_i;
        taken.first = first_i;
        taken.last = last_i;
        if (score_beat(taken, fresh)) expected_scores.push_back(fresh);
      end
    end
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at the reset penalties (open 29, extend 3). Loads first carry the
    // extreme entries and alternating bit patterns; the first one has both path flags
    // set, which a load must ignore.
    send_idle_rate = 4;
    recv_idle_rate = 4;
    queue_load(16'h0000, 16'sh7fff, 1'b1, 1'b1);
    queue_load(16'hffff, 16'sh8000, 1'b0, 1'b0);
    queue_load(16'hff00, -16'sd1, 1'b0, 1'b0);
    queue_load(16'h00ff, 16'sd0, 1'b0, 1'b0);
    queue_load(16'haa55, 16'sh5555, 1'b0, 1'b0);
    queue_load(16'h55aa, 16'shaaaa, 1'b0, 1'b0);
    // A path through every column kind: deletion run, insertion straight after it,
    // the spare kind, and a deletion that must open again after it.
    queue_column(agps_pkg::KIND_MATCH, 16'h0000, 1'b1, 1'b0);
    queue_column(agps_pkg::KIND_MATCH, 16'hffff, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_DEL, 16'haa55, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_DEL, 16'haa55, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_INS, 16'h55aa, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_INS, 16'h55aa, 1'b0, 1'b0);
    queue_column(KIND_SPARE, 16'h0000, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_DEL, 16'hffff, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_MATCH, 16'h00ff, 1'b0, 1'b1);
    // A single column that is first and last at once.
    queue_column(agps_pkg::KIND_MATCH, 16'hff00, 1'b1, 1'b1);
    // No first flag: the score goes on from where the last path left it.
    queue_column(agps_pkg::KIND_DEL, 16'hff00, 1'b0, 1'b1);
    // A load followed at once by a match that reads the same entry.
    queue_load(16'h0102, 16'sd100, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_MATCH, 16'h0102, 1'b1, 1'b1);
    // A gap as the opening column, then a gap run with a load in between, which does not break the run.
    queue_column(agps_pkg::KIND_INS, 16'h0102, 1'b1, 1'b1);
    queue_column(agps_pkg::KIND_DEL, 16'h55aa, 1'b1, 1'b0);
    queue_load(16'h0304, 16'sd7, 1'b1, 1'b0);
    queue_column(agps_pkg::KIND_DEL, 16'h0304, 1'b0, 1'b1);
    wait_drained(4);

    // Zero open penalty against the largest extend penalty. Halfway through, the sender
    // holds off until every result of the first half has been received.
    write_reg(agps_pkg::REG_GAP_OPEN, 10'd0);
    write_reg(agps_pkg::REG_GAP_EXTEND, 10'd1023);
    send_idle_rate = 3;
    recv_idle_rate = 0;
    queue_random_items(100);
    wait_drained(0);
    send_idle_rate = 5;
    recv_idle_rate = 5;
    queue_random_items(100);
    wait_drained(4);

    // The other extreme, with the receiver doing most of the stalling.
    write_reg(agps_pkg::REG_GAP_OPEN, 10'd1023);
    write_reg(agps_pkg::REG_GAP_EXTEND, 10'd0);
    send_idle_rate = 0;
    recv_idle_rate = 3;
    queue_random_items(200);
    wait_drained(4);

    write_reg(agps_pkg::REG_GAP_OPEN, 10'($urandom));
    write_reg(agps_pkg::REG_GAP_EXTEND, 10'($urandom));
    send_idle_rate = 6;
    recv_idle_rate = 6;
    queue_random_items(200);
    wait_drained(4);

    // From here on neither side idles.
    write_reg(agps_pkg::REG_GAP_OPEN, 10'($urandom));
    write_reg(agps_pkg::REG_GAP_EXTEND, 10'($urandom));
    send_idle_rate = 0;
    recv_idle_rate = 0;
    queue_random_items(200);
    wait_drained(4);

    // A short tail at large penalties: the largest and the smallest entry around a
    // deletion and an insertion, and a path that opens again with first.
    write_reg(agps_pkg::REG_GAP_OPEN, 10'd1023);
    write_reg(agps_pkg::REG_GAP_EXTEND, 10'd512);
    queue_load(16'h0707, 16'sh7fff, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_MATCH, 16'h0707, 1'b1, 1'b0);
    queue_column(agps_pkg::KIND_DEL, 16'h0707, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_DEL, 16'h0707, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_MATCH, 16'hffff, 1'b0, 1'b1);
    queue_column(agps_pkg::KIND_MATCH, 16'hffff, 1'b1, 1'b0);
    queue_column(agps_pkg::KIND_INS, 16'hffff, 1'b0, 1'b0);
    queue_column(agps_pkg::KIND_MATCH, 16'h0000, 1'b0, 1'b1);
    queue_column(agps_pkg::KIND_MATCH, 16'h0102, 1'b1, 1'b1);
    wait_drained(8);

    if (mismatch_count == 0 && expected_scores.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
